>>> src/dttb_pkg.sv
// ----------------------------------------------------------------------------
// dttb_pkg: shared types and constants for the time tag converter
// Holds the payload structs between the stages and the reciprocal constants
// used for the constant divisions.
// ----------------------------------------------------------------------------
package dttb_pkg;

   typedef struct packed {
      logic [31:0]        seq_seconds;
      logic [31:0]        seconds_offset;
      logic [19:0]        micro_offset;
      logic signed [31:0] group_delay;
   } dttb_tag_type;

   typedef struct packed {
      logic [31:0] unix_seconds;
      logic [19:0] microseconds;
      logic        underflow;
   } dttb_time_type;

   typedef struct packed {
      logic [31:0] unix_seconds;
      logic [19:0] microseconds;
      logic [11:0] year;
      logic [8:0]  day_of_year;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [13:0] ticks;
      logic [6:0]  sub_tick_micro;
      logic        underflow;
   } dttb_result_type;

   localparam logic [31:0] EPOCH_RESET     = 32'd946684800;

   // bias keeps the microsecond adjustment non-negative, a whole number of seconds
   localparam logic [33:0] DELAY_BIAS      = 34'd2148000000;
   localparam logic [11:0] BIAS_SECONDS    = 12'd2148;

   // floor(n / 1e6) = ((n >> 6) * RECIP_MEGA) >> 41, exact for n < 2^33
   localparam logic [27:0] RECIP_MEGA      = 28'd140737489;
   localparam logic [19:0] MICROS_PER_SEC  = 20'd1000000;

   // floor(n / 86400) = ((n >> 7) * RECIP_DAY) >> 35, exact for 32-bit n
   localparam logic [25:0] RECIP_DAY       = 26'd50903317;
   localparam logic [16:0] SECS_PER_DAY    = 17'd86400;

   // floor(n / 3600) = ((n >> 4) * RECIP_HOUR) >> 21
   localparam logic [13:0] RECIP_HOUR      = 14'd9321;
   localparam logic [11:0] SECS_PER_HOUR   = 12'd3600;

   // floor(n / 60) = ((n >> 2) * RECIP_MIN) >> 14
   localparam logic [10:0] RECIP_MIN       = 11'd1093;
   localparam logic [5:0]  SECS_PER_MIN    = 6'd60;

   // floor(n / 100) = ((n >> 2) * RECIP_TICK) >> 23
   localparam logic [18:0] RECIP_TICK      = 19'd335545;
   localparam logic [6:0]  TICK_MICROS     = 7'd100;

   // floor(n / 1461) = (n * RECIP_QUAD) >> 27, exact for 16-bit n
   localparam logic [16:0] RECIP_QUAD      = 17'd91868;
   localparam logic [10:0] DAYS_PER_QUAD   = 11'd1461;

   // day count is rebased to 1968-01-01 so every four-year group opens with a leap year
   localparam logic [15:0] QUAD_BASE_DAYS  = 16'd731;
   localparam logic [11:0] BASE_YEAR       = 12'd1968;
   // first day after 2100-02-28 counted from 1970; 2100 is no leap year
   localparam logic [15:0] SKIP_DAY        = 16'd47541;
   localparam logic [11:0] SKIP_YEAR       = 12'd2100;
   localparam logic [10:0] YEAR1_START     = 11'd366;
   localparam logic [10:0] YEAR2_START     = 11'd731;
   localparam logic [10:0] YEAR3_START     = 11'd1096;

endpackage

>>> src/dttb_tag.sv
// ----------------------------------------------------------------------------
// dttb_tag: time tag to unix seconds and microseconds
// Four stages: seconds sum and delay adjustment, reciprocal multiply, remainder
// and seconds carry, clamp and epoch add.
// ----------------------------------------------------------------------------
module dttb_tag (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  dttb_pkg::dttb_tag_type in_tag,
   input  logic [31:0]            epoch_offset,
   output logic                   out_valid,
   input  logic                   out_ready,
   output dttb_pkg::dttb_time_type out_time
);
   import dttb_pkg::*;

   logic [3:0]    v_ff;
   logic [3:0]    rdy;

   logic [32:0]   sum_secs_ff, sum_secs_in;
   logic [32:0]   adj_ff, adj_in;
   logic [33:0]   adj_wide;

   logic [32:0]   sum2_ff;
   logic [32:0]   adj2_ff;
   logic [13:0]   quot_ff, quot_in;
   logic [54:0]   recip_prod;

   logic [33:0]   mega_prod;
   logic [33:0]   frac_wide;
   logic [34:0]   secs_wide;
   logic [19:0]   frac_ff, frac_in;
   logic [31:0]   secs_low_ff, secs_low_in;
   logic          under_ff, under_in;

   dttb_time_type time_ff, time_in;

   // a stage takes new data when it is empty or its successor moves on
   always_comb begin
      rdy[3] = !v_ff[3] || out_ready;
      rdy[2] = !v_ff[2] || rdy[3];
      rdy[1] = !v_ff[1] || rdy[2];
      rdy[0] = !v_ff[0] || rdy[1];
   end

   always_comb begin
      sum_secs_in = {1'b0, in_tag.seq_seconds} + {1'b0, in_tag.seconds_offset};
      adj_wide    = {14'b0, in_tag.micro_offset}
                  - {{2{in_tag.group_delay[31]}}, in_tag.group_delay} + DELAY_BIAS;
      adj_in      = adj_wide[32:0];

      recip_prod  = 55'(adj_ff[32:6]) * 55'(RECIP_MEGA);
      quot_in     = recip_prod[54:41];

      mega_prod   = 34'(quot_ff) * 34'(MICROS_PER_SEC);
      frac_wide   = {1'b0, adj2_ff} - mega_prod;
      frac_in     = frac_wide[19:0];
      secs_wide   = {2'b0, sum2_ff} + {21'b0, quot_ff} - {23'b0, BIAS_SECONDS};
      under_in    = secs_wide[34];
      secs_low_in = secs_wide[31:0];

      // negative total clamps to zero, leaving only the epoch
      time_in.underflow    = under_ff;
      time_in.unix_seconds = under_ff ? epoch_offset : secs_low_ff + epoch_offset;
      time_in.microseconds = under_ff ? 20'd0 : frac_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         if (rdy[1]) v_ff[1] <= v_ff[0];
         if (rdy[2]) v_ff[2] <= v_ff[1];
         if (rdy[3]) v_ff[3] <= v_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         sum_secs_ff <= sum_secs_in;
         adj_ff      <= adj_in;
      end
      if (rdy[1]) begin
         sum2_ff <= sum_secs_ff;
         adj2_ff <= adj_ff;
         quot_ff <= quot_in;
      end
      if (rdy[2]) begin
         frac_ff     <= frac_in;
         under_ff    <= under_in;
         secs_low_ff <= secs_low_in;
      end
      if (rdy[3]) begin
         time_ff <= time_in;
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[3];
   assign out_time  = time_ff;

endmodule

>>> src/dttb_cal.sv
// ----------------------------------------------------------------------------
// dttb_cal: unix seconds to UTC calendar fields
// Six stages of constant reciprocal multiplies and back-subtractions giving
// year, day of year, time of day and the tick split of the microseconds.
// ----------------------------------------------------------------------------
module dttb_cal (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  dttb_pkg::dttb_time_type  in_time,
   output logic                     out_valid,
   input  logic                     out_ready,
   output dttb_pkg::dttb_result_type out_result
);
   import dttb_pkg::*;

   logic [5:0]    v_ff;
   logic [5:0]    rdy;

   // stage a: day count and tick count
   dttb_time_type ta_ff;
   logic [50:0]   day_prod;
   logic [36:0]   tick_prod;
   logic [15:0]   days_ff, days_in;
   logic [13:0]   ticks_a_ff, ticks_a_in;

   // stage b: seconds of day, sub-tick, rebased day count
   dttb_time_type tb_ff;
   logic [32:0]   day_secs;
   logic [32:0]   rem_wide;
   logic [20:0]   tick_us;
   logic [20:0]   sub_wide;
   logic [16:0]   dadj_wide;
   logic [16:0]   rem_ff, rem_in;
   logic [6:0]    sub_b_ff, sub_b_in;
   logic [13:0]   ticks_b_ff;
   logic          skip_b_ff, skip_b_in;
   logic [15:0]   dadj_ff, dadj_in;

   // stage c: hour and four-year group
   dttb_time_type tc_ff;
   logic [26:0]   hour_prod;
   logic [32:0]   quad_prod;
   logic [16:0]   rem_c_ff;
   logic [15:0]   dadj_c_ff;
   logic [4:0]    hour_c_ff, hour_c_in;
   logic [5:0]    quad_c_ff, quad_c_in;
   logic [6:0]    sub_c_ff;
   logic [13:0]   ticks_c_ff;
   logic          skip_c_ff;

   // stage d: seconds of hour, day within group
   dttb_time_type td_ff;
   logic [16:0]   hour_secs;
   logic [16:0]   rem2_wide;
   logic [16:0]   quad_days;
   logic [16:0]   r4_wide;
   logic [11:0]   rem2_ff, rem2_in;
   logic [10:0]   r4_ff, r4_in;
   logic [4:0]    hour_d_ff;
   logic [5:0]    quad_d_ff;
   logic [6:0]    sub_d_ff;
   logic [13:0]   ticks_d_ff;
   logic          skip_d_ff;

   // stage e: minute, year, zero-based day of year
   dttb_time_type te_ff;
   logic [20:0]   min_prod;
   logic [5:0]    minute_ff, minute_in;
   logic [1:0]    yr_sel;
   logic [10:0]   yr_start;
   logic [10:0]   doy0_wide;
   logic [8:0]    doy0_ff, doy0_in;
   logic [11:0]   year_ff, year_in;
   logic [11:0]   rem2_e_ff;
   logic [4:0]    hour_e_ff;
   logic [6:0]    sub_e_ff;
   logic [13:0]   ticks_e_ff;
   logic          skip_e_ff;

   // stage f: second and final day of year
   logic [11:0]   min_secs;
   logic [11:0]   sec_wide;
   logic          doy_fix;
   dttb_result_type res_ff, res_in;

   always_comb begin
      rdy[5] = !v_ff[5] || out_ready;
      rdy[4] = !v_ff[4] || rdy[5];
      rdy[3] = !v_ff[3] || rdy[4];
      rdy[2] = !v_ff[2] || rdy[3];
      rdy[1] = !v_ff[1] || rdy[2];
      rdy[0] = !v_ff[0] || rdy[1];
   end

   always_comb begin
      day_prod   = 51'(in_time.unix_seconds[31:7]) * 51'(RECIP_DAY);
      days_in    = day_prod[50:35];
      tick_prod  = 37'(in_time.microseconds[19:2]) * 37'(RECIP_TICK);
      ticks_a_in = tick_prod[36:23];

      day_secs   = 33'(days_ff) * 33'(SECS_PER_DAY);
      rem_wide   = {1'b0, ta_ff.unix_seconds} - day_secs;
      rem_in     = rem_wide[16:0];
      tick_us    = 21'(ticks_a_ff) * 21'(TICK_MICROS);
      sub_wide   = {1'b0, ta_ff.microseconds} - tick_us;
      sub_b_in   = sub_wide[6:0];
      // past 2100-02-28 insert a phantom leap day so the four-year rule holds
      skip_b_in  = (days_ff >= SKIP_DAY);
      dadj_wide  = {1'b0, days_ff} + {16'b0, skip_b_in} + {1'b0, QUAD_BASE_DAYS};
      dadj_in    = dadj_wide[15:0];

      hour_prod  = 27'(rem_ff[16:4]) * 27'(RECIP_HOUR);
      hour_c_in  = hour_prod[25:21];
      quad_prod  = 33'(dadj_ff) * 33'(RECIP_QUAD);
      quad_c_in  = quad_prod[32:27];

      hour_secs  = 17'(hour_c_ff) * 17'(SECS_PER_HOUR);
      rem2_wide  = rem_c_ff - hour_secs;
      rem2_in    = rem2_wide[11:0];
      quad_days  = 17'(quad_c_ff) * 17'(DAYS_PER_QUAD);
      r4_wide    = {1'b0, dadj_c_ff} - quad_days;
      r4_in      = r4_wide[10:0];

      min_prod   = 21'(rem2_ff[11:2]) * 21'(RECIP_MIN);
      minute_in  = min_prod[19:14];
      if (r4_ff >= YEAR3_START) begin
         yr_sel   = 2'd3;
         yr_start = YEAR3_START;
      end else if (r4_ff >= YEAR2_START) begin
         yr_sel   = 2'd2;
         yr_start = YEAR2_START;
      end else if (r4_ff >= YEAR1_START) begin
         yr_sel   = 2'd1;
         yr_start = YEAR1_START;
      end else begin
         yr_sel   = 2'd0;
         yr_start = 11'd0;
      end
      doy0_wide  = r4_ff - yr_start;
      doy0_in    = doy0_wide[8:0];
      year_in    = BASE_YEAR + {4'b0, quad_d_ff, 2'b00} + {10'b0, yr_sel};

      min_secs   = 12'(minute_ff) * 12'(SECS_PER_MIN);
      sec_wide   = rem2_e_ff - min_secs;
      // the phantom leap day shifts the rest of 2100 by one
      doy_fix    = skip_e_ff && (year_ff == SKIP_YEAR);

      res_in.unix_seconds   = te_ff.unix_seconds;
      res_in.microseconds   = te_ff.microseconds;
      res_in.underflow      = te_ff.underflow;
      res_in.year           = year_ff;
      res_in.day_of_year    = doy0_ff + 9'd1 - {8'b0, doy_fix};
      res_in.hour           = hour_e_ff;
      res_in.minute         = minute_ff;
      res_in.second         = sec_wide[5:0];
      res_in.ticks          = ticks_e_ff;
      res_in.sub_tick_micro = sub_e_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         if (rdy[1]) v_ff[1] <= v_ff[0];
         if (rdy[2]) v_ff[2] <= v_ff[1];
         if (rdy[3]) v_ff[3] <= v_ff[2];
         if (rdy[4]) v_ff[4] <= v_ff[3];
         if (rdy[5]) v_ff[5] <= v_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         ta_ff      <= in_time;
         days_ff    <= days_in;
         ticks_a_ff <= ticks_a_in;
      end
      if (rdy[1]) begin
         tb_ff      <= ta_ff;
         rem_ff     <= rem_in;
         sub_b_ff   <= sub_b_in;
         ticks_b_ff <= ticks_a_ff;
         skip_b_ff  <= skip_b_in;
         dadj_ff    <= dadj_in;
      end
      if (rdy[2]) begin
         tc_ff      <= tb_ff;
         rem_c_ff   <= rem_ff;
         dadj_c_ff  <= dadj_ff;
         hour_c_ff  <= hour_c_in;
         quad_c_ff  <= quad_c_in;
         sub_c_ff   <= sub_b_ff;
         ticks_c_ff <= ticks_b_ff;
         skip_c_ff  <= skip_b_ff;
      end
      if (rdy[3]) begin
         td_ff      <= tc_ff;
         rem2_ff    <= rem2_in;
         r4_ff      <= r4_in;
         hour_d_ff  <= hour_c_ff;
         quad_d_ff  <= quad_c_ff;
         sub_d_ff   <= sub_c_ff;
         ticks_d_ff <= ticks_c_ff;
         skip_d_ff  <= skip_c_ff;
      end
      if (rdy[4]) begin
         te_ff      <= td_ff;
         minute_ff  <= minute_in;
         doy0_ff    <= doy0_in;
         year_ff    <= year_in;
         rem2_e_ff  <= rem2_ff;
         hour_e_ff  <= hour_d_ff;
         sub_e_ff   <= sub_d_ff;
         ticks_e_ff <= ticks_d_ff;
         skip_e_ff  <= skip_d_ff;
      end
      if (rdy[5]) begin
         res_ff <= res_in;
      end
   end

   assign in_ready   = rdy[0];
   assign out_valid  = v_ff[5];
   assign out_result = res_ff;

endmodule

>>> src/digitizer_time_to_btime_unit.sv
// a req_ transfer reaches rsp_tvalid through the ten register stages
// throughput: one item per cycle while rsp_tready holds; every stage is a constant multiply or add and compare
// stalls on rsp_tready pass back combinationally through the ready chain, empty stages still fill
// reset clears all stage valid bits and loads epoch_offset with 946684800
// ----------------------------------------------------------------------------
// digitizer_time_to_btime_unit: digitizer time tag to UTC calendar time
// Forms seconds and microseconds from the time tag, adds the epoch offset
// and breaks the result into year, day of year and time of day.
// ----------------------------------------------------------------------------
module digitizer_time_to_btime_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // seq_seconds[31:0], seconds_offset[63:32], micro_offset[83:64],
   // group_delay[115:84], zero pad[119:116]
   input  logic [119:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // unix_seconds[31:0], microseconds[51:32], year[63:52], day_of_year[72:64],
   // hour[77:73], minute[83:78], second[89:84], ticks[103:90],
   // sub_tick_micro[110:104], zero pad[111]
   output logic [111:0]  rsp_tdata,
   // underflow[0]
   output logic          rsp_tuser,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [31:0]   csr_wdata
);
   import dttb_pkg::*;

   logic            epoch_ff;
   logic [31:0]     epoch_offset_ff;
   dttb_tag_type    tag;
   dttb_time_type   mid_time;
   logic            mid_valid;
   logic            mid_ready;
   dttb_result_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_offset_ff <= EPOCH_RESET;
         epoch_ff        <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            epoch_offset_ff <= csr_wdata;
         end
         epoch_ff <= 1'b1;
      end
   end

   // register port takes a transfer in every cycle once epoch_ff is set after reset
   assign csr_ready = epoch_ff;

   always_comb begin
      tag.seq_seconds    = req_tdata[31:0];
      tag.seconds_offset = req_tdata[63:32];
      tag.micro_offset   = req_tdata[83:64];
      tag.group_delay    = req_tdata[115:84];
   end

   dttb_tag u_tag (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_tag       (tag),
      .epoch_offset (epoch_offset_ff),
      .out_valid    (mid_valid),
      .out_ready    (mid_ready),
      .out_time     (mid_time)
   );

   dttb_cal u_cal (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (mid_valid),
      .in_ready   (mid_ready),
      .in_time    (mid_time),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {1'b0, result.sub_tick_micro, result.ticks, result.second,
                       result.minute, result.hour, result.day_of_year, result.year,
                       result.microseconds, result.unix_seconds};
   assign rsp_tuser = result.underflow;

endmodule
